// ===== src/fvpb_pkg.sv =====
// shared constants, codes and widths of the four-voice pulse beeper
package fvpb_pkg;

  localparam int VOICES     = 4;
  localparam int VOICE_W    = $clog2(VOICES);
  localparam int PHASE_W    = VOICE_W + 1;
  localparam int BYTE_W     = 8;
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int ADDR_W     = VOICE_W + LANE_W;
  localparam int REGS       = VOICES * LANES;
  localparam int ACC_W      = 16;
  localparam int LVL_W      = BYTE_W + 1;
  localparam int RECENT_N   = 8;
  localparam int COUNT_W    = 4;
  localparam int AUDIO_W    = 16;
  localparam int SCOPE_W    = 15;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // byte lanes of one voice row
  localparam logic [LANE_W-1:0] LANE_STEP_LO = 2'd0;
  localparam logic [LANE_W-1:0] LANE_STEP_HI = 2'd1;
  localparam logic [LANE_W-1:0] LANE_DUTY    = 2'd2;
  localparam logic [LANE_W-1:0] LANE_VOLUME  = 2'd3;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_IDX_MUTE   = 1'b0;
  localparam logic CFG_IDX_SMOOTH = 1'b1;

  localparam logic [BYTE_W-1:0]  DUTY_RESET = 8'h80;
  localparam logic [SCOPE_W-1:0] SCOPE_FULL = 15'd32767;
  localparam logic [SCOPE_W-1:0] SCOPE_HALF = 15'd16383;
  localparam logic [AUDIO_W-1:0] AUDIO_HIGH = 16'h7fff;

endpackage

// ===== src/four_voice_pulse_beeper.sv =====
// four-voice one-bit pulse beeper: register file and accumulators in memories, two stages
//
//   channel   direction  tdata                                   tuser
//   in_       slave      reg_addr[3:0], reg_data[11:4]           kind
//   out_      master     audio_level[15:0], scope_voice[17:16],  scope_valid
//                        scope_level[32:18]
//   cfg_      apb        0x0 mute_mask, 0x4 smooth_mode          -
//
// one item per cycle sustained while the output is not stalled; a tick's result passes
// through the register file and accumulator memory read registers, then the output register
// a write item updates the register file at its own beat and gives no result
// a stalled output stops the input once the compute stage also holds a beat
// synchronous active-low reset; memory contents stand behind per-entry valid bits
module four_voice_pulse_beeper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fvpb_pkg::IN_DATA_W-1:0]      in_tdata,   // reg_addr, reg_data
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fvpb_pkg::OUT_DATA_W-1:0]     out_tdata,  // audio_level, scope_voice, scope_level
  output logic                                out_tuser,  // scope_valid
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fvpb_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [fvpb_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [fvpb_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic [fvpb_pkg::VOICES-1:0]                       mute_r;
  logic                                              smooth_r;
  logic [fvpb_pkg::PHASE_W-1:0]                      phase_r;

  logic [fvpb_pkg::LANES-1:0][fvpb_pkg::BYTE_W-1:0]  rf_mem [fvpb_pkg::VOICES];
  logic [fvpb_pkg::REGS-1:0]                         rf_vld_r;
  logic [fvpb_pkg::LANES-1:0][fvpb_pkg::BYTE_W-1:0]  rf_rd_r;
  logic [fvpb_pkg::LANES-1:0]                        rf_rdv_r;

  logic [fvpb_pkg::ACC_W-1:0]                        acc_mem [fvpb_pkg::VOICES];
  logic [fvpb_pkg::VOICES-1:0]                       acc_vld_r;
  logic [fvpb_pkg::ACC_W-1:0]                        acc_rd_r;
  logic                                              acc_rdv_r;

  logic                                              s1_valid_r;
  logic [fvpb_pkg::PHASE_W-1:0]                      s1_phase_r;
  logic                                              lvl3_r;
  logic [fvpb_pkg::RECENT_N-1:0]                     recent_r;

  logic                                              out_valid_r;
  logic [fvpb_pkg::OUT_DATA_W-1:0]                   out_data_r;
  logic                                              out_user_r;

  logic                                              in_acc;
  logic                                              tick_acc;
  logic                                              wr_acc;
  logic                                              s1_adv;
  logic                                              cfg_wr;
  logic [fvpb_pkg::ADDR_W-1:0]                       in_addr;
  logic [fvpb_pkg::BYTE_W-1:0]                       in_byte;
  logic [fvpb_pkg::VOICE_W-1:0]                      rd_voice;
  logic [fvpb_pkg::VOICE_W-1:0]                      s1_voice;
  logic                                              s1_even;
  logic [fvpb_pkg::LANES-1:0][fvpb_pkg::BYTE_W-1:0]  row;
  logic [fvpb_pkg::ACC_W-1:0]                        acc_q;
  logic [fvpb_pkg::ACC_W-1:0]                        acc_sum;
  logic [fvpb_pkg::LVL_W-1:0]                        lvl;
  logic                                              muted;
  logic                                              out_bit;
  logic [fvpb_pkg::SCOPE_W-1:0]                      scope_level;
  logic [fvpb_pkg::RECENT_N-1:0]                     recent_nxt;
  logic [fvpb_pkg::COUNT_W-1:0]                      ones;
  logic [fvpb_pkg::AUDIO_W-1:0]                      audio;

  assign in_addr  = in_tdata[fvpb_pkg::ADDR_W-1:0];
  assign in_byte  = in_tdata[fvpb_pkg::ADDR_W +: fvpb_pkg::BYTE_W];
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc   = in_tvalid && in_tready;
  assign tick_acc = in_acc && (in_tuser == fvpb_pkg::KIND_TICK);
  assign wr_acc   = in_acc && (in_tuser == fvpb_pkg::KIND_WRITE);
  assign rd_voice = phase_r[fvpb_pkg::PHASE_W-1:1];
  assign s1_voice = s1_phase_r[fvpb_pkg::PHASE_W-1:1];
  assign s1_even  = !s1_phase_r[0];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      fvpb_pkg::CFG_IDX_MUTE: begin
        cfg_prdata = fvpb_pkg::CFG_DATA_W'(mute_r);
      end
      fvpb_pkg::CFG_IDX_SMOOTH: begin
        cfg_prdata = fvpb_pkg::CFG_DATA_W'(smooth_r);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r   <= '0;
      smooth_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        fvpb_pkg::CFG_IDX_MUTE: begin
          mute_r <= cfg_pwdata[fvpb_pkg::VOICES-1:0];
        end
        fvpb_pkg::CFG_IDX_SMOOTH: begin
          smooth_r <= cfg_pwdata[0];
        end
        default: begin
          mute_r <= mute_r;
        end
      endcase
    end
  end

  // register file memory, one row per voice
  always_ff @(posedge clk) begin
    if (wr_acc) begin
      rf_mem[in_addr[fvpb_pkg::ADDR_W-1:fvpb_pkg::LANE_W]][in_addr[fvpb_pkg::LANE_W-1:0]]
        <= in_byte;
    end
    if (tick_acc) begin
      rf_rd_r  <= rf_mem[rd_voice];
      rf_rdv_r <= rf_vld_r[rd_voice*fvpb_pkg::LANES +: fvpb_pkg::LANES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wr_acc) begin
      rf_vld_r[in_addr] <= 1'b1;
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (s1_adv && s1_even) begin
      acc_mem[s1_voice] <= acc_sum;
    end
    if (tick_acc) begin
      acc_rd_r  <= acc_mem[rd_voice];
      acc_rdv_r <= acc_vld_r[rd_voice];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (s1_adv && s1_even) begin
      acc_vld_r[s1_voice] <= 1'b1;
    end
  end

  // phase counter and compute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (tick_acc) begin
        phase_r <= phase_r + fvpb_pkg::PHASE_W'(1);
      end
      if (tick_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_phase_r <= phase_r;
    end
  end

  // compute stage
  always_comb begin
    for (int b = 0; b < fvpb_pkg::LANES; b++) begin
      if (rf_rdv_r[b]) begin
        row[b] = rf_rd_r[b];
      end else if (fvpb_pkg::LANE_W'(b) == fvpb_pkg::LANE_DUTY) begin
        row[b] = fvpb_pkg::DUTY_RESET;
      end else begin
        row[b] = '0;
      end
    end
    acc_q   = acc_rdv_r ? acc_rd_r : '0;
    acc_sum = acc_q + {row[fvpb_pkg::LANE_STEP_HI], row[fvpb_pkg::LANE_STEP_LO]};
    lvl     = {1'b0, row[fvpb_pkg::LANE_VOLUME]}
            + fvpb_pkg::LVL_W'(acc_sum[fvpb_pkg::ACC_W-1 -: fvpb_pkg::BYTE_W]
                               < row[fvpb_pkg::LANE_DUTY]);
    muted   = mute_r[s1_voice];
    out_bit = !muted && (s1_even ? lvl[4] : lvl3_r);

    if (!s1_even || muted || lvl[4:3] == 2'b00) begin
      scope_level = '0;
    end else if (lvl[4:3] == 2'b11) begin
      scope_level = fvpb_pkg::SCOPE_FULL;
    end else begin
      scope_level = fvpb_pkg::SCOPE_HALF;
    end

    recent_nxt = recent_r;
    if (smooth_r) begin
      recent_nxt[s1_phase_r] = out_bit;
    end
    ones = '0;
    for (int i = 0; i < fvpb_pkg::RECENT_N; i++) begin
      ones = ones + fvpb_pkg::COUNT_W'(recent_nxt[i]);
    end

    if (smooth_r) begin
      audio = {ones, 12'd0} - fvpb_pkg::AUDIO_W'(1);
    end else if (out_bit) begin
      audio = fvpb_pkg::AUDIO_HIGH;
    end else begin
      audio = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl3_r   <= 1'b0;
      recent_r <= '0;
    end else if (s1_adv) begin
      recent_r <= recent_nxt;
      if (s1_even) begin
        lvl3_r <= lvl[3];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {7'd0, scope_level,
                     s1_even ? s1_voice : fvpb_pkg::VOICE_W'(0), audio};
      out_user_r <= s1_even;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/fvpb_checker.sv =====
// port-level checks of the four-voice pulse beeper and their binding
module fvpb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [fvpb_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                out_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // audio is zero, full scale or a multiple of 4096 minus one
  a_audio_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:0] == 12'hfff || out_tdata[15:0] == 16'h0000))
    else $error("audio level outside its value set");

  // no scope data on odd phases
  a_scope_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[32:16] == 17'd0)
    else $error("scope fields set without scope_valid");

  // scope level is one of three values
  a_scope_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:18] == 15'd0 || out_tdata[32:18] == fvpb_pkg::SCOPE_HALF ||
                    out_tdata[32:18] == fvpb_pkg::SCOPE_FULL))
    else $error("scope level outside its value set");

endmodule

bind four_voice_pulse_beeper fvpb_checker u_fvpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/testbench.sv =====
// self-checking testbench of the four-voice pulse beeper: stream and apb drivers, sample tracker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [fvpb_pkg::AUDIO_W-1:0] audio;
    logic                         scope_valid;
    logic [fvpb_pkg::VOICE_W-1:0] scope_voice;
    logic [fvpb_pkg::SCOPE_W-1:0] scope_level;
  } beeper_sample_t;

  class pulse_mix_tracker;
    logic [fvpb_pkg::BYTE_W-1:0]   reg_bytes [fvpb_pkg::REGS];
    logic [fvpb_pkg::ACC_W-1:0]    accum [fvpb_pkg::VOICES];
    logic [9:0]                    level [fvpb_pkg::VOICES];
    logic [fvpb_pkg::PHASE_W-1:0]  phase;
    logic [fvpb_pkg::RECENT_N-1:0] recent;
    logic [fvpb_pkg::VOICES-1:0]   mute;
    logic                          smooth;
    beeper_sample_t                pending_samples [$];
    int                            errors;

    function new();
      for (int r = 0; r < fvpb_pkg::REGS; r++) begin
        reg_bytes[r] = (r[fvpb_pkg::LANE_W-1:0] == fvpb_pkg::LANE_DUTY) ?
                       fvpb_pkg::DUTY_RESET : '0;
      end
      for (int v = 0; v < fvpb_pkg::VOICES; v++) begin
        accum[v] = '0;
        level[v] = '0;
      end
      phase  = '0;
      recent = '0;
      mute   = '0;
      smooth = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function void take_item(logic kind, logic [fvpb_pkg::ADDR_W-1:0] addr,
                            logic [fvpb_pkg::BYTE_W-1:0] data);
      beeper_sample_t               s;
      logic [fvpb_pkg::VOICE_W-1:0] v;
      logic [fvpb_pkg::BYTE_W:0]    sum;
      logic                         out_bit;
      if (kind == fvpb_pkg::KIND_WRITE) begin
        reg_bytes[addr] = data;
        return;
      end
      s = '0;
      v = phase[fvpb_pkg::PHASE_W-1:1];
      if (!phase[0]) begin
        accum[v] = accum[v] + {reg_bytes[{v, fvpb_pkg::LANE_STEP_HI}],
                               reg_bytes[{v, fvpb_pkg::LANE_STEP_LO}]};
        sum = reg_bytes[{v, fvpb_pkg::LANE_VOLUME}]
            + (accum[v][15:8] < reg_bytes[{v, fvpb_pkg::LANE_DUTY}]);
        level[v] = {1'b0, sum};
        s.scope_valid = 1'b1;
        s.scope_voice = v;
        if (mute[v] || level[v][4:3] == 2'b00) begin
          s.scope_level = '0;
        end else if (level[v][4:3] == 2'b11) begin
          s.scope_level = fvpb_pkg::SCOPE_FULL;
        end else begin
          s.scope_level = fvpb_pkg::SCOPE_HALF;
        end
      end
      out_bit = !mute[v] && level[v][4];
      if (smooth) begin
        recent[phase] = out_bit;
        s.audio = fvpb_pkg::AUDIO_W'($countones(recent) * 4096 - 1);
      end else begin
        s.audio = out_bit ? fvpb_pkg::AUDIO_HIGH : '0;
      end
      level[v] = level[v] << 1;
      phase = phase + 1'b1;
      pending_samples.push_back(s);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_sample(logic [fvpb_pkg::OUT_DATA_W-1:0] tdata, logic tuser);
      beeper_sample_t want;
      if (pending_samples.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual tdata %h tuser %b",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      compare_field("audio_level", want.audio, tdata[15:0]);
      compare_field("scope_valid", want.scope_valid, tuser);
      compare_field("scope_voice", want.scope_voice, tdata[17:16]);
      compare_field("scope_level", want.scope_level, tdata[32:18]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fvpb_pkg::IN_DATA_W-1:0]  in_tdata;   // reg_addr, reg_data
  logic                            in_tuser;   // kind
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fvpb_pkg::OUT_DATA_W-1:0] out_tdata;  // audio_level, scope_voice, scope_level
  logic                            out_tuser;  // scope_valid
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [fvpb_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [fvpb_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [fvpb_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  pulse_mix_tracker tracker;
  bit               quiet = 1'b0;
  int               rx_hold = 0;
  int unsigned      cycle_count = 0;

  four_voice_pulse_beeper DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL four_voice_pulse_beeper");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      if (rx_hold == 0) out_tready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_hold = $urandom_range(1, 3);
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_sample(out_tdata, out_tuser);
  end

  task automatic send_item(input logic kind, input logic [fvpb_pkg::ADDR_W-1:0] addr,
                           input logic [fvpb_pkg::BYTE_W-1:0] data);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(fvpb_pkg::IN_DATA_W - fvpb_pkg::BYTE_W - fvpb_pkg::ADDR_W){1'b0}},
                  data, addr};
    do @(posedge clk); while (!in_tready);
    tracker.take_item(kind, addr, data);
    @(negedge clk);
  endtask

  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [fvpb_pkg::CFG_DATA_W-1:0] value);
    logic [fvpb_pkg::CFG_DATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == fvpb_pkg::CFG_IDX_MUTE) tracker.mute = value[fvpb_pkg::VOICES-1:0];
    else tracker.smooth = value[0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    if (readback != value) begin
      $display("%0t mismatch register %0d readback: expected %0d actual %0d",
               $time, idx, value, readback);
      tracker.errors++;
    end
  endtask

  task automatic configure(input logic [fvpb_pkg::VOICES-1:0] mute, input logic smooth);
    settle(8);
    set_register(fvpb_pkg::CFG_IDX_MUTE, fvpb_pkg::CFG_DATA_W'(mute));
    set_register(fvpb_pkg::CFG_IDX_SMOOTH, fvpb_pkg::CFG_DATA_W'(smooth));
  endtask

  task automatic random_items(input int count, input int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) settle(0);
      if ($urandom_range(0, 9) < 7) begin
        send_item(fvpb_pkg::KIND_TICK, fvpb_pkg::ADDR_W'($urandom),
                  fvpb_pkg::BYTE_W'($urandom));
      end else begin
        send_item(fvpb_pkg::KIND_WRITE, fvpb_pkg::ADDR_W'($urandom),
                  fvpb_pkg::BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = fvpb_pkg::KIND_TICK;
    out_tready  = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tracker     = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes: full step, duty 0 and 255, volume bit patterns, reset duty
    send_item(fvpb_pkg::KIND_WRITE, {2'd0, fvpb_pkg::LANE_STEP_LO}, 8'hff);
    send_item(fvpb_pkg::KIND_WRITE, {2'd0, fvpb_pkg::LANE_STEP_HI}, 8'hff);
    send_item(fvpb_pkg::KIND_WRITE, {2'd0, fvpb_pkg::LANE_DUTY},    8'hff);
    send_item(fvpb_pkg::KIND_WRITE, {2'd0, fvpb_pkg::LANE_VOLUME},  8'h18);
    send_item(fvpb_pkg::KIND_WRITE, {2'd1, fvpb_pkg::LANE_DUTY},    8'h00);
    send_item(fvpb_pkg::KIND_WRITE, {2'd1, fvpb_pkg::LANE_VOLUME},  8'hff);
    send_item(fvpb_pkg::KIND_WRITE, {2'd2, fvpb_pkg::LANE_STEP_HI}, 8'h80);
    send_item(fvpb_pkg::KIND_WRITE, {2'd2, fvpb_pkg::LANE_VOLUME},  8'h10);
    send_item(fvpb_pkg::KIND_WRITE, {2'd3, fvpb_pkg::LANE_STEP_LO}, 8'h01);
    send_item(fvpb_pkg::KIND_WRITE, {2'd3, fvpb_pkg::LANE_VOLUME},  8'h08);
    repeat (12) send_item(fvpb_pkg::KIND_TICK, fvpb_pkg::ADDR_W'($urandom),
                          fvpb_pkg::BYTE_W'($urandom));

    configure(4'h0, 1'b1);
    random_items(170, -1);
    configure(4'h0, 1'b0);
    random_items(170, -1);
    configure(fvpb_pkg::VOICES'($urandom), 1'b1);
    random_items(170, 85);
    configure(4'hf, 1'b0);
    random_items(170, -1);
    configure(4'hf, 1'b1);
    random_items(170, -1);
    configure(fvpb_pkg::VOICES'($urandom), 1'b0);
    quiet = 1'b1;
    random_items(170, -1);

    settle(16);
    if (tracker.errors == 0) begin
      $display("PASS four_voice_pulse_beeper");
    end else begin
      $display("FAIL four_voice_pulse_beeper");
    end
    $finish;
  end
endmodule
